// File: design/sds_pkg.sv
// Shared types and constants of the SCAN disk scheduler.
// No dependencies; used by scan_disk_scheduler_core and tb_top.
package sds_pkg;

   localparam int TRACK_W = 16;
   localparam int DISK_W  = 17;
   localparam int SUM_W   = 22;
   localparam int CSR_W   = 2;

   typedef logic [TRACK_W-1:0] track_type;
   typedef logic [CSR_W-1:0]   csr_index_type;

   localparam csr_index_type CSR_DISK_TRACKS = 2'd0;
   localparam csr_index_type CSR_START_HEAD  = 2'd1;
   localparam csr_index_type CSR_SWEEP_UP    = 2'd2;

   localparam logic [DISK_W-1:0] DISK_TRACKS_RST = 17'd200;
   localparam track_type         START_HEAD_RST  = 16'd0;
   localparam logic              SWEEP_UP_RST    = 1'b1;

endpackage

// File: design/sds_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sds_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 17
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/scan_disk_scheduler_core.sv
// SCAN elevator disk scheduler: request store, selection sequencer, result register.
// Depends on sds_pkg and sds_ram.
// Throughput: one request word per cycle while idle; the batch_end word then passes
// through ST_STOP, and each result takes a scan of the store, ST_FLUSH and ST_DECIDE,
// plus one extra scan at the turnaround, by the single compare unit (one entry a cycle).
// Reset: synchronous, clears control state and loads the register defaults.
module scan_disk_scheduler_core #(
   parameter int MAX_REQUESTS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  sds_pkg::csr_index_type        csr_index,
   input  logic [sds_pkg::DISK_W-1:0]    csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [sds_pkg::TRACK_W-1:0]   req_track,
   input  logic                          req_batch_end,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sds_pkg::TRACK_W-1:0]   rsp_from_track,
   output logic [sds_pkg::TRACK_W-1:0]   rsp_to_track,
   output logic [sds_pkg::TRACK_W-1:0]   rsp_seek_distance,
   output logic [sds_pkg::SUM_W-1:0]     rsp_total_seek,
   output logic                          rsp_final_move
);

   localparam int DEPTH = MAX_REQUESTS + 1;
   localparam int CNT_W = $clog2(DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STOP,
      ST_SCAN,
      ST_FLUSH,
      ST_DECIDE
   } state_type;

   state_type                   state_ff, state_in;
   logic [sds_pkg::DISK_W-1:0]  disk_tracks_ff, disk_tracks_in;
   sds_pkg::track_type          start_head_ff, start_head_in;
   logic                        sweep_up_ff, sweep_up_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [CNT_W-1:0]            scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]            rd_idx_ff, rd_idx_in;
   logic                        rd_vld_ff, rd_vld_in;
   logic                        found_ff, found_in;
   sds_pkg::track_type          best_ff, best_in;
   logic [CNT_W-1:0]            best_idx_ff, best_idx_in;
   logic                        phase_ff, phase_in;
   logic [CNT_W-1:0]            emit_cnt_ff, emit_cnt_in;
   logic [DEPTH-1:0]            done_ff, done_in;
   sds_pkg::track_type          head_ff, head_in;
   logic [sds_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   sds_pkg::track_type          rsp_from_ff, rsp_from_in;
   sds_pkg::track_type          rsp_to_ff, rsp_to_in;
   sds_pkg::track_type          rsp_dist_ff, rsp_dist_in;
   logic [sds_pkg::SUM_W-1:0]   rsp_total_ff, rsp_total_in;
   logic                        rsp_final_ff, rsp_final_in;

   logic                        ram_we;
   sds_pkg::track_type          ram_wdata;
   sds_pkg::track_type          ram_rdata;
   sds_pkg::track_type          top_track;
   sds_pkg::track_type          stop_track;
   logic                        ent_upper;
   logic                        cur_upper;
   logic                        better;
   logic                        take;
   sds_pkg::track_type          seek_dist;
   logic [sds_pkg::SUM_W-1:0]   sum_next;
   logic                        is_final;
   logic                        rsp_load;

   sds_ram #(
      .WIDTH (sds_pkg::TRACK_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cnt_ff),
      .wr_data (ram_wdata),
      .rd_addr (scan_idx_ff),
      .rd_data (ram_rdata)
   );

   // end stop: top track saturates at 16 bits, zero tracks gives track 0
   always_comb begin
      if (disk_tracks_ff == '0) begin
         top_track = '0;
      end else if (disk_tracks_ff[sds_pkg::DISK_W-1]) begin
         top_track = '1;
      end else begin
         top_track = disk_tracks_ff[sds_pkg::TRACK_W-1:0] - sds_pkg::TRACK_W'(1);
      end
   end

   assign stop_track = sweep_up_ff ? top_track : '0;
   assign ram_we     = (state_ff == ST_IDLE && req_valid && cnt_ff < CNT_W'(MAX_REQUESTS))
                       || state_ff == ST_STOP;
   assign ram_wdata  = (state_ff == ST_STOP) ? stop_track : req_track;

   // selection compare: min of upper group going up, max of lower group going down
   assign cur_upper = sweep_up_ff ^ phase_ff;
   assign ent_upper = (rd_idx_ff == cnt_ff) ? sweep_up_ff : (ram_rdata >= start_head_ff);
   assign better    = cur_upper ? (ram_rdata < best_ff) : (ram_rdata > best_ff);
   assign take      = rd_vld_ff && !done_ff[rd_idx_ff] && (ent_upper == cur_upper)
                      && (!found_ff || better);

   assign seek_dist = (best_ff >= head_ff) ? best_ff - head_ff : head_ff - best_ff;
   assign sum_next  = sum_ff + sds_pkg::SUM_W'(seek_dist);
   assign is_final  = (emit_cnt_ff == cnt_ff);
   assign rsp_load  = state_ff == ST_DECIDE && found_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in       = state_ff;
      disk_tracks_in = disk_tracks_ff;
      start_head_in  = start_head_ff;
      sweep_up_in    = sweep_up_ff;
      cnt_in         = cnt_ff;
      scan_idx_in    = scan_idx_ff;
      rd_idx_in      = rd_idx_ff;
      rd_vld_in      = 1'b0;
      found_in       = found_ff;
      best_in        = best_ff;
      best_idx_in    = best_idx_ff;
      phase_in       = phase_ff;
      emit_cnt_in    = emit_cnt_ff;
      done_in        = done_ff;
      head_in        = head_ff;
      sum_in         = sum_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_from_in    = rsp_from_ff;
      rsp_to_in      = rsp_to_ff;
      rsp_dist_in    = rsp_dist_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_final_in   = rsp_final_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write) begin
         unique case (csr_index)
            sds_pkg::CSR_DISK_TRACKS: disk_tracks_in = csr_wdata;
            sds_pkg::CSR_START_HEAD:  start_head_in  = csr_wdata[sds_pkg::TRACK_W-1:0];
            sds_pkg::CSR_SWEEP_UP:    sweep_up_in    = csr_wdata[0];
            default: ;
         endcase
      end

      if (take) begin
         found_in    = 1'b1;
         best_in     = ram_rdata;
         best_idx_in = rd_idx_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (cnt_ff < CNT_W'(MAX_REQUESTS)) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               if (req_batch_end) begin
                  state_in = ST_STOP;
               end
            end
         end
         ST_STOP: begin
            head_in     = start_head_ff;
            sum_in      = '0;
            done_in     = '0;
            emit_cnt_in = '0;
            phase_in    = 1'b0;
            scan_idx_in = '0;
            found_in    = 1'b0;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            rd_vld_in = 1'b1;
            rd_idx_in = scan_idx_ff;
            if (scan_idx_ff == cnt_ff) begin
               state_in = ST_FLUSH;
            end else begin
               scan_idx_in = scan_idx_ff + CNT_W'(1);
            end
         end
         ST_FLUSH: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!found_ff) begin
               scan_idx_in = '0;
               if (!phase_ff) begin
                  phase_in = 1'b1;
                  state_in = ST_SCAN;
               end else begin
                  cnt_in   = '0;
                  state_in = ST_IDLE;
               end
            end else if (rsp_load) begin
               rsp_valid_in          = 1'b1;
               rsp_from_in           = head_ff;
               rsp_to_in             = best_ff;
               rsp_dist_in           = seek_dist;
               rsp_total_in          = sum_next;
               rsp_final_in          = is_final;
               done_in[best_idx_ff]  = 1'b1;
               head_in               = best_ff;
               sum_in                = sum_next;
               emit_cnt_in           = emit_cnt_ff + CNT_W'(1);
               found_in              = 1'b0;
               scan_idx_in           = '0;
               if (is_final) begin
                  cnt_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         disk_tracks_ff <= sds_pkg::DISK_TRACKS_RST;
         start_head_ff  <= sds_pkg::START_HEAD_RST;
         sweep_up_ff    <= sds_pkg::SWEEP_UP_RST;
         cnt_ff         <= '0;
         scan_idx_ff    <= '0;
         rd_vld_ff      <= 1'b0;
         found_ff       <= 1'b0;
         phase_ff       <= 1'b0;
         emit_cnt_ff    <= '0;
         done_ff        <= '0;
         head_ff        <= '0;
         sum_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         disk_tracks_ff <= disk_tracks_in;
         start_head_ff  <= start_head_in;
         sweep_up_ff    <= sweep_up_in;
         cnt_ff         <= cnt_in;
         scan_idx_ff    <= scan_idx_in;
         rd_vld_ff      <= rd_vld_in;
         found_ff       <= found_in;
         phase_ff       <= phase_in;
         emit_cnt_ff    <= emit_cnt_in;
         done_ff        <= done_in;
         head_ff        <= head_in;
         sum_ff         <= sum_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rd_idx_ff    <= rd_idx_in;
      best_ff      <= best_in;
      best_idx_ff  <= best_idx_in;
      rsp_from_ff  <= rsp_from_in;
      rsp_to_ff    <= rsp_to_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_total_ff <= rsp_total_in;
      rsp_final_ff <= rsp_final_in;
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_from_track    = rsp_from_ff;
   assign rsp_to_track      = rsp_to_ff;
   assign rsp_seek_distance = rsp_dist_ff;
   assign rsp_total_seek    = rsp_total_ff;
   assign rsp_final_move    = rsp_final_ff;

`ifndef SYNTHESIS
   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_ff != ST_STOP) |-> (emit_cnt_ff <= cnt_ff))
      else $error("more words emitted than stops in batch");

   a_pick_unused: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && found_ff) |-> !done_ff[best_idx_ff])
      else $error("selected stop already served");

   a_final_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && is_final) |=> (state_ff == ST_IDLE && cnt_ff == '0))
      else $error("final word did not return sequencer to idle");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking bench for scan_disk_scheduler_core: directed and random track batches against
// a SCAN elevator predictor. Depends on sds_pkg and the scheduler RTL.
`timescale 1ns / 100ps

module tb_top;

   localparam int                     MAX_REQ     = 16;
   localparam int                     CYCLE_LIMIT = 1_000_000;
   localparam sds_pkg::csr_index_type CSR_UNUSED  = 2'd3;

   typedef struct packed {
      sds_pkg::track_type trk;
      logic               is_end;
   } req_word_type;

   typedef struct packed {
      sds_pkg::track_type        from_trk;
      sds_pkg::track_type        to_trk;
      sds_pkg::track_type        span;
      logic [sds_pkg::SUM_W-1:0] total;
      logic                      is_end;
   } move_type;

   logic                       clock         = 1'b0;
   logic                       reset         = 1'b1;
   logic                       csr_write     = 1'b0;
   sds_pkg::csr_index_type     csr_index     = sds_pkg::CSR_DISK_TRACKS;
   logic [sds_pkg::DISK_W-1:0] csr_wdata     = '0;
   logic                       req_valid     = 1'b0;
   logic                       req_stall;
   sds_pkg::track_type         req_track     = '0;
   logic                       req_batch_end = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall     = 1'b0;
   sds_pkg::track_type         rsp_from_track;
   sds_pkg::track_type         rsp_to_track;
   sds_pkg::track_type         rsp_seek_distance;
   logic [sds_pkg::SUM_W-1:0]  rsp_total_seek;
   logic                       rsp_final_move;

   // shadow registers and predictor state
   logic [sds_pkg::DISK_W-1:0] cfg_tracks = sds_pkg::DISK_TRACKS_RST;
   sds_pkg::track_type         cfg_head   = sds_pkg::START_HEAD_RST;
   logic                       cfg_up     = sds_pkg::SWEEP_UP_RST;
   sds_pkg::track_type         held[$];
   req_word_type               req_words[$];
   move_type                   moves_due[$];

   logic                       quiet = 1'b0;
   int                         send_gap = 0;
   int                         hold_left = 0;
   int                         cycles = 0;
   int                         errors = 0;
   int                         words_sent = 0;
   int                         batches = 0;
   int                         moves_seen = 0;
   int                         settings = 0;
   req_word_type               next_word;
   move_type                   got;
   move_type                   want;

   scan_disk_scheduler_core #(
      .MAX_REQUESTS(MAX_REQ)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_track         (req_track),
      .req_batch_end     (req_batch_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_from_track    (rsp_from_track),
      .rsp_to_track      (rsp_to_track),
      .rsp_seek_distance (rsp_seek_distance),
      .rsp_total_seek    (rsp_total_seek),
      .rsp_final_move    (rsp_final_move)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Store one request; on the batch end word, order the stops and queue the moves.
   // Sort key: sweep-first group gets prefix 0; downward groups use inverted track.
   function automatic void schedule_request(input sds_pkg::track_type trk,
                                            input logic is_end);
      logic [16:0]               key [0:MAX_REQ];
      sds_pkg::track_type        stop [0:MAX_REQ];
      logic [16:0]               kv;
      sds_pkg::track_type        tv, top, pos, span;
      logic [sds_pkg::SUM_W-1:0] sum;
      logic                      up_grp;
      int                        n, i, j;
      move_type                  mv;
      if (held.size() < MAX_REQ) held.push_back(trk);
      if (!is_end) return;
      if (cfg_tracks == '0) top = '0;
      else if (cfg_tracks > 17'd65536) top = '1;
      else top = sds_pkg::track_type'(cfg_tracks - 17'd1);
      n = 0;
      for (i = 0; i <= held.size(); i++) begin
         if (i < held.size()) begin
            tv = held[i];
            up_grp = (tv >= cfg_head);
         end else begin
            tv = cfg_up ? top : '0;
            up_grp = cfg_up;
         end
         kv = {up_grp != cfg_up, up_grp ? tv : ~tv};
         j = n;
         while (j > 0 && key[j-1] > kv) begin
            key[j] = key[j-1];
            stop[j] = stop[j-1];
            j--;
         end
         key[j] = kv;
         stop[j] = tv;
         n++;
      end
      pos = cfg_head;
      sum = '0;
      for (i = 0; i < n; i++) begin
         span = (stop[i] >= pos) ? stop[i] - pos : pos - stop[i];
         sum = sum + sds_pkg::SUM_W'(span);
         mv.from_trk = pos;
         mv.to_trk = stop[i];
         mv.span = span;
         mv.total = sum;
         mv.is_end = (i == n - 1);
         moves_due.push_back(mv);
         pos = stop[i];
      end
      held.delete();
      batches++;
   endfunction

   task automatic log_miss(input string what, input move_type w, input move_type g);
      errors++;
      if (errors <= 10)
         $display("ERROR %s: expected from=%0d to=%0d seek=%0d total=%0d end=%0b, %s",
                  what, w.from_trk, w.to_trk, w.span, w.total, w.is_end,
                  $sformatf("got from=%0d to=%0d seek=%0d total=%0d end=%0b",
                            g.from_trk, g.to_trk, g.span, g.total, g.is_end));
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) schedule_request(req_track, req_batch_end);
         if (!req_valid || !req_stall) begin
            if (send_gap > 0 || req_words.size() == 0) begin
               if (send_gap > 0) send_gap--;
               req_valid <= 1'b0;
            end else begin
               next_word = req_words.pop_front();
               req_valid <= 1'b1;
               req_track <= next_word.trk;
               req_batch_end <= next_word.is_end;
               send_gap = pick_gap();
               words_sent++;
            end
         end
      end
   end

   // move monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.from_trk = rsp_from_track;
            got.to_trk = rsp_to_track;
            got.span = rsp_seek_distance;
            got.total = rsp_total_seek;
            got.is_end = rsp_final_move;
            moves_seen++;
            if (moves_due.size() == 0) begin
               log_miss("unexpected move", '0, got);
            end else begin
               want = moves_due.pop_front();
               if (got !== want) log_miss("move mismatch", want, got);
            end
         end
         if (hold_left == 0) hold_left = pick_gap();
         rsp_stall <= (hold_left > 0);
         if (hold_left > 0) hold_left--;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d moves still due", cycles, moves_due.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic program_geometry(input logic [sds_pkg::DISK_W-1:0] tracks,
                                   input sds_pkg::track_type head,
                                   input logic up, input logic poke_unused);
      csr_write <= 1'b1;
      csr_index <= sds_pkg::CSR_DISK_TRACKS;
      csr_wdata <= tracks;
      @(posedge clock);
      csr_index <= sds_pkg::CSR_START_HEAD;
      csr_wdata <= sds_pkg::DISK_W'(head);
      @(posedge clock);
      csr_index <= sds_pkg::CSR_SWEEP_UP;
      csr_wdata <= sds_pkg::DISK_W'(up);
      @(posedge clock);
      if (poke_unused) begin
         csr_index <= CSR_UNUSED;
         csr_wdata <= sds_pkg::DISK_W'($urandom);
         @(posedge clock);
      end
      csr_write <= 1'b0;
      cfg_tracks = tracks;
      cfg_head = head;
      cfg_up = up;
      settings++;
      @(negedge clock);
      quiet = ($urandom_range(0, 3) == 0);
   endtask

   task automatic queue_word(input sds_pkg::track_type trk, input logic is_end);
      req_word_type w;
      w.trk = trk;
      w.is_end = is_end;
      req_words.push_back(w);
   endtask

   // wait for the block to go idle before touching registers
   task automatic settle();
      do @(negedge clock);
      while (req_words.size() != 0 || req_valid || moves_due.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [sds_pkg::DISK_W-1:0] tracks;
      sds_pkg::track_type         head, trk;
      int                         top_lim, len, k, rand_words;
      rand_words = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed batches
      program_geometry(17'd200, 16'd100, 1'b1, 1'b0);
      queue_word(16'd100, 1'b0);
      queue_word(16'd176, 1'b0);
      queue_word(16'd79, 1'b0);
      queue_word(16'd34, 1'b0);
      queue_word(16'd11, 1'b1);
      settle();
      program_geometry(17'd200, 16'd100, 1'b0, 1'b0);
      queue_word(16'd0, 1'b0);
      queue_word(16'hFFFF, 1'b0);
      queue_word(16'd199, 1'b0);
      queue_word(16'd100, 1'b1);
      settle();
      // empty disk, head above the top track
      program_geometry('0, 16'hFFFF, 1'b1, 1'b0);
      queue_word(16'h5555, 1'b0);
      queue_word(16'hAAAA, 1'b0);
      queue_word(16'd0, 1'b1);
      settle();
      program_geometry('1, 16'd0, 1'b0, 1'b1);
      queue_word(16'hFFFF, 1'b1);
      queue_word(16'd0, 1'b1);
      settle();
      program_geometry(17'd65536, 16'hFFFF, 1'b1, 1'b0);
      queue_word(16'd12345, 1'b0);
      queue_word(16'hFFFF, 1'b1);
      settle();
      program_geometry(17'd1, 16'd0, 1'b1, 1'b0);
      queue_word(16'd0, 1'b1);
      settle();

      // random geometries and batches
      while (rand_words < 200) begin
         case ($urandom_range(0, 7))
            0:       tracks = '0;
            1:       tracks = 17'd1;
            2:       tracks = 17'd65536;
            3:       tracks = '1;
            default: tracks = sds_pkg::DISK_W'($urandom_range(2, 4000));
         endcase
         top_lim = (tracks == '0) ? 0 : (tracks > 17'd65536) ? 65535 : int'(tracks) - 1;
         case ($urandom_range(0, 5))
            0:       head = '0;
            1:       head = '1;
            2:       head = sds_pkg::track_type'($urandom);
            default: head = sds_pkg::track_type'($urandom_range(0, top_lim));
         endcase
         program_geometry(tracks, head, 1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0);
         repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 9))
               0:       len = $urandom_range(MAX_REQ + 1, MAX_REQ + 4);
               1:       len = MAX_REQ;
               default: len = $urandom_range(1, 8);
            endcase
            for (k = 0; k < len; k++) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: trk = sds_pkg::track_type'($urandom);
                  4, 5, 6:    trk = sds_pkg::track_type'($urandom_range(0, top_lim));
                  7:          trk = head;
                  8:          trk = sds_pkg::track_type'(head + $urandom_range(0, 6) - 3);
                  default:    trk = $urandom_range(0, 1) ? '1
                                                         : sds_pkg::track_type'(top_lim);
               endcase
               queue_word(trk, k == len - 1);
            end
            rand_words += len;
         end
         settle();
      end

      repeat (40) @(posedge clock);
      if (moves_due.size() != 0) errors++;
      $display("Sent %0d request words in %0d batches over %0d register settings,",
               words_sent, batches, settings);
      $display("checked %0d head moves, %0d errors", moves_seen, errors);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: scan_disk_scheduler_core.f
design/sds_pkg.sv
design/sds_ram.sv
design/scan_disk_scheduler_core.sv
tb/tb_top.sv
